// File: hw/rtl/tpagc_pkg.sv
// tpagc_pkg: shared widths, state and operation codes, and the
// command/status bundles between the controller and the datapath.
// No dependencies.
package tpagc_pkg;

	localparam int MAX_PIXELS_DEF = 65536;
	localparam int BIN_COUNT_DEF  = 4096;

	localparam int NW   = 17;   // pixel count and frame size width
	localparam int PIXW = 16;
	localparam int FRAC = 16;   // fraction bits of the window values
	localparam int QW   = 34;   // signed window word
	localparam int DIVW = 48;   // divider operand width
	localparam int DBW  = 6;    // divider step count width
	localparam int CHGW = 23;

	localparam logic [NW-1:0] FRAME_PIXELS_RST = 17'd49152;

	// quotient bit counts per division
	localparam logic [DBW-1:0] MEAN_BITS = 6'd16;
	localparam logic [DBW-1:0] CHG_BITS  = 6'd23;
	localparam logic [DBW-1:0] PIX_BITS  = 6'd8;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_LD1, S_LD2, S_DR1, S_DR2, S_DR3, S_DRDIV, S_DREMIT,
		S_P100, S_P100W, S_WALK, S_WALKE, S_TGT, S_EL, S_ELW, S_EH, S_EHW,
		S_MEAN, S_MEANW, S_CHG, S_CHGW, S_SEMIT
	} state_t;

	typedef enum logic [2:0] {
		OP_P100, OP_ELO, OP_EHI, OP_MEAN, OP_CHG, OP_PIX
	} div_op_t;

	typedef struct packed {
		logic    cap;
		logic    ld_wr;
		logic    dr_calc;
		logic    dr_sel;
		logic    clr;
		logic    walk;
		logic    tgt;
		logic    restart;
		logic    div_start;
		div_op_t div_op;
		logic    emit_pix;
		logic    emit_stat;
	} cmd_t;

	typedef struct packed {
		logic req_in;
		logic pending;
		logic complete;
		logic div_done;
		logic cnt_last;
		logic direct;
		logic restart;
		logic out_free;
	} sts_t;

endpackage

// File: hw/rtl/tpagc_div.sv
// tpagc_div: shared restoring divider, one quotient bit per cycle.
// The caller gives the quotient bit count; depends on tpagc_pkg.
module tpagc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tpagc_pkg::DIVW-1:0] num,
	input  logic [tpagc_pkg::DIVW-1:0] den,
	input  logic [tpagc_pkg::DBW-1:0]  bits,
	output logic                       done,
	output logic [tpagc_pkg::DIVW-1:0] quo
);
	import tpagc_pkg::*;

	logic            busy_q;
	logic            done_q;
	logic [DBW-1:0]  cnt_q;
	logic [DIVW-1:0] rem_q;
	logic [DIVW-1:0] dsh_q;
	logic [DIVW-1:0] quo_q;
	logic            ge;

	assign ge   = rem_q >= dsh_q;
	assign done = done_q;
	assign quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= bits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DBW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= den << (bits - 1'b1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) rem_q <= rem_q - dsh_q;
			quo_q <= {quo_q[DIVW-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

endmodule

// File: hw/rtl/tpagc_dp.sv
// tpagc_dp: frame banks, histogram, running statistics, window smoothing,
// pixel scaling and the output register. Depends on tpagc_pkg, tpagc_div.
module tpagc_dp #(
	parameter int MAX_PIXELS = tpagc_pkg::MAX_PIXELS_DEF,
	parameter int BIN_COUNT  = tpagc_pkg::BIN_COUNT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tpagc_pkg::cmd_t            cmd,
	output tpagc_pkg::sts_t            sts,
	input  logic                       req_type,
	input  logic [15:0]                raw_pixel,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [16:0]                cfg_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       result_kind,
	output logic [7:0]                 pixel_out,
	output logic                       is_last,
	output logic [15:0]                frame_min,
	output logic [15:0]                frame_max,
	output logic [15:0]                frame_mean,
	output logic [22:0]                change_x100,
	output logic signed [16:0]         window_low_int,
	output logic [16:0]                window_high_int
);
	import tpagc_pkg::*;

	localparam int PW = $clog2(MAX_PIXELS);
	localparam int BW = $clog2(BIN_COUNT);
	localparam logic [NW-1:0] MAXP = NW'(MAX_PIXELS);
	localparam logic [11:0] BIN_MAX12 = 12'(BIN_COUNT - 1);
	localparam logic [BW-1:0] BIN_LAST = BW'(BIN_COUNT - 1);
	localparam logic signed [QW-1:0] Q_ONE   = QW'(65536);
	localparam logic signed [QW-1:0] DEN_MIN = QW'(24 * 65536);
	localparam logic signed [QW-1:0] SPAN_MIN = QW'(64 * 65536);
	localparam logic signed [QW-1:0] HALF_WIN = QW'(32 * 65536);
	// reciprocals: n/100 as (n * P100_MUL) >> 23, y/5 as (y * DIV5_MUL) >> 23
	localparam logic [16:0] P100_MUL = 17'd83887;
	localparam logic [20:0] DIV5_MUL = 21'd1677722;

	// architectural state
	logic [NW-1:0]         frame_pixels_q;
	logic                  bank_q;
	logic                  prior_q;
	logic [NW-1:0]         load_idx_q;
	logic [NW-1:0]         drain_idx_q;
	logic [NW-1:0]         done_cnt_q;
	logic                  pending_q;
	logic [15:0]           rmin_q;
	logic [15:0]           rmax_q;
	logic [31:0]           rsum_q;
	logic [31:0]           csum_q;
	logic signed [QW-1:0]  wl_q;
	logic signed [QW-1:0]  wh_q;
	logic [BW-1:0]         cnt_q;
	logic                  walk_vld_s1;
	logic                  out_valid_q;
	logic                  aux_busy_q;
	logic                  aux_done_q;
	logic [1:0]            aux_cnt_q;

	// working registers
	logic                  req_q;
	logic [15:0]           pix_q;
	logic [15:0]           bank_a [MAX_PIXELS];
	logic [15:0]           bank_b [MAX_PIXELS];
	logic [15:0]           rd_a_s1;
	logic [15:0]           rd_b_s1;
	logic [16:0]           hist_mem [BIN_COUNT];
	logic [16:0]           hist_rd_s1;
	logic [BW-1:0]         walk_idx_s1;
	logic [NW:0]           cum_q;
	logic [NW:0]           lo_t_q;
	logic [NW:0]           hi_t_q;
	logic                  lo_found_q;
	logic                  hi_found_q;
	logic [BW-1:0]         lo_bin_q;
	logic [BW-1:0]         hi_bin_q;
	logic signed [QW-1:0]  tlo_q;
	logic signed [QW-1:0]  thi_q;
	div_op_t               op_q;
	logic                  dneg_q;
	logic [DIVW-1:0]       num_q;
	logic [DIVW-1:0]       den_q;
	logic                  neg_q;
	logic [DIVW-1:0]       chg100_q;
	logic [15:0]           mean_q;
	logic [CHGW-1:0]       chg_q;
	logic [7:0]            pixo_q;
	logic                  kind_q;
	logic [7:0]            opix_q;
	logic                  last_q;
	logic [15:0]           omin_q;
	logic [15:0]           omax_q;
	logic [15:0]           omean_q;
	logic [CHGW-1:0]       ochg_q;
	logic [16:0]           owl_q;
	logic [16:0]           owh_q;
	logic [35:0]           aux_x_q;
	logic [2:0]            aux_rem_q;
	logic [35:0]           aux_quo_q;

	// combinational
	logic [BW-1:0]         bin;
	logic [NW-1:0]         eff;
	logic [NW-1:0]         n_next;
	logic [15:0]           prev_v;
	logic [15:0]           absdiff;
	logic [PW-1:0]         ridx;
	logic [BW-1:0]         haddr;
	logic [BW-1:0]         hwaddr;
	logic [16:0]           hwdata;
	logic                  hwe;
	logic signed [35:0]    vdiff;
	logic signed [44:0]    num45;
	logic signed [35:0]    den36;
	logic signed [35:0]    denc;
	logic                  sat;
	logic signed [QW:0]    ema_d;
	logic signed [QW:0]    ema_mag;
	logic                  aux_start;
	logic                  div_go;
	logic [20:0]           aux_y;
	logic [41:0]           aux_prod;
	logic [17:0]           aux_qc;
	logic [20:0]           aux_r21;
	logic [33:0]           p100_prod;
	logic [DIVW-1:0]       div_num;
	logic [DIVW-1:0]       div_den;
	logic [DBW-1:0]        div_bits;
	logic                  div_done;
	logic [DIVW-1:0]       div_quo;
	logic [NW:0]           p100;
	logic [NW:0]           lo_t;
	logic [NW:0]           hi_t;
	logic [NW:0]           cum_next;
	logic [BW+3:0]         lo_i;
	logic [BW+3:0]         hi_i;
	logic signed [QW-1:0]  lo_f;
	logic signed [QW-1:0]  hi_f;
	logic signed [QW-1:0]  mid_f;
	logic signed [QW-1:0]  tlo;
	logic signed [QW-1:0]  thi;
	logic                  have_prev;
	logic                  pix_last;

	function automatic logic [16:0] to_int(input logic signed [QW-1:0] w);
		logic signed [QW-FRAC-1:0] f;
		begin
			f = (QW-FRAC)'(w >>> FRAC);
			// truncate toward zero for negative values
			if (w < 0 && w[FRAC-1:0] != '0) f = f + 1'b1;
			return f[16:0];
		end
	endfunction

	assign cfg_ready = 1'b1;

	assign bin = (pix_q[15:4] > BIN_MAX12) ? BIN_LAST : pix_q[4 +: BW];
	always_comb begin
		if (frame_pixels_q == '0) eff = NW'(1);
		else if (frame_pixels_q > MAXP) eff = MAXP;
		else eff = frame_pixels_q;
	end
	assign n_next  = load_idx_q + 1'b1;
	assign prev_v  = bank_q ? rd_a_s1 : rd_b_s1;
	assign absdiff = (pix_q > prev_v) ? pix_q - prev_v : prev_v - pix_q;
	assign ridx    = req_q ? drain_idx_q[PW-1:0] : load_idx_q[PW-1:0];
	assign have_prev = prior_q && (done_cnt_q == load_idx_q);
	assign pix_last  = (drain_idx_q + 1'b1) >= done_cnt_q;

	// drain scaling: num = (v - low) * 255, den = max(24, high - low)
	assign vdiff = $signed({4'b0, prev_v, 16'b0}) - 36'(wl_q);
	assign num45 = (45'(vdiff) <<< 8) - 45'(vdiff);
	assign den36 = 36'(wh_q) - 36'(wl_q);
	assign denc  = (den36 < 36'(DEN_MIN)) ? 36'(DEN_MIN) : den36;
	assign sat   = num_q >= (den_q << 8);

	// smoothing step distance
	assign ema_d   = (cmd.div_op == OP_ELO) ? (QW+1)'(tlo_q) - (QW+1)'(wl_q)
	                                        : (QW+1)'(thi_q) - (QW+1)'(wh_q);
	assign ema_mag = (ema_d < 0) ? -ema_d : ema_d;

	// constant divisions: n/100 in one step, (2|d|+5)/10 = (|d|+2)/5 in two
	// 18-bit digit steps
	assign aux_start = cmd.div_start &&
		(cmd.div_op == OP_P100 || cmd.div_op == OP_ELO || cmd.div_op == OP_EHI);
	assign div_go    = cmd.div_start && !aux_start;
	assign aux_y     = {aux_rem_q, aux_x_q[35:18]};
	assign aux_prod  = {21'b0, aux_y} * {21'b0, DIV5_MUL};
	assign aux_qc    = aux_prod[40:23];
	assign aux_r21   = aux_y - (21'({aux_qc, 2'b0}) + 21'(aux_qc));
	assign p100_prod = {17'b0, load_idx_q} * {17'b0, P100_MUL};

	always_comb begin
		unique case (cmd.div_op)
			OP_MEAN: begin
				div_num  = DIVW'(rsum_q);
				div_den  = DIVW'(load_idx_q);
				div_bits = MEAN_BITS;
			end
			OP_CHG: begin
				div_num  = chg100_q;
				div_den  = DIVW'(load_idx_q);
				div_bits = CHG_BITS;
			end
			OP_PIX: begin
				div_num  = num_q;
				div_den  = den_q;
				div_bits = PIX_BITS;
			end
			default: begin
				div_num  = '0;
				div_den  = DIVW'(1);
				div_bits = DBW'(1);
			end
		endcase
	end

	tpagc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.num    (div_num),
		.den    (div_den),
		.bits   (div_bits),
		.done   (div_done),
		.quo    (div_quo)
	);

	// percentile thresholds from n/100
	always_comb begin
		p100 = (NW+1)'(aux_quo_q[10:0]);
		lo_t = (p100 > (NW+1)'(1)) ? p100 : (NW+1)'(1);
		hi_t = (NW+1)'(load_idx_q) - p100;
		if (hi_t < lo_t + 1'b1) hi_t = lo_t + 1'b1;
	end
	assign cum_next = cum_q + (NW+1)'(hist_rd_s1);

	// targets, widened to at least 64 around the midpoint
	always_comb begin
		lo_i  = {lo_bin_q, 4'h0};
		hi_i  = {hi_bin_q, 4'hf};
		lo_f  = $signed(QW'({lo_i, 16'b0}));
		hi_f  = $signed(QW'({hi_i, 16'b0}));
		mid_f = (lo_f + hi_f) >>> 1;
		if (hi_f - lo_f < SPAN_MIN) begin
			tlo = mid_f - HALF_WIN;
			thi = mid_f + HALF_WIN;
		end else begin
			tlo = lo_f;
			thi = hi_f;
		end
	end

	// histogram port: walk reads and clears, the clear pass zeroes, loads increment
	assign haddr = cmd.walk ? cnt_q : bin;
	always_comb begin
		hwe    = cmd.ld_wr || cmd.clr || cmd.walk;
		hwaddr = cmd.ld_wr ? bin : cnt_q;
		hwdata = cmd.ld_wr ? hist_rd_s1 + 1'b1 : '0;
	end

	always_ff @(posedge clk) begin
		hist_rd_s1 <= hist_mem[haddr];
		if (hwe) hist_mem[hwaddr] <= hwdata;
	end

	always_ff @(posedge clk) begin
		rd_a_s1 <= bank_a[ridx];
		rd_b_s1 <= bank_b[ridx];
		if (cmd.ld_wr) begin
			if (bank_q) bank_b[load_idx_q[PW-1:0]] <= pix_q;
			else bank_a[load_idx_q[PW-1:0]] <= pix_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pixels_q <= FRAME_PIXELS_RST;
			bank_q         <= 1'b0;
			prior_q        <= 1'b0;
			load_idx_q     <= '0;
			drain_idx_q    <= '0;
			done_cnt_q     <= '0;
			pending_q      <= 1'b0;
			rmin_q         <= 16'hffff;
			rmax_q         <= '0;
			rsum_q         <= '0;
			csum_q         <= '0;
			wl_q           <= -Q_ONE;
			wh_q           <= -Q_ONE;
			cnt_q          <= '0;
			walk_vld_s1    <= 1'b0;
			out_valid_q    <= 1'b0;
			aux_busy_q     <= 1'b0;
			aux_done_q     <= 1'b0;
			aux_cnt_q      <= '0;
		end else begin
			walk_vld_s1 <= cmd.walk;
			aux_done_q  <= 1'b0;
			if (aux_start) begin
				aux_busy_q <= 1'b1;
				aux_cnt_q  <= (cmd.div_op == OP_P100) ? 2'd1 : 2'd2;
			end else if (aux_busy_q) begin
				aux_cnt_q <= aux_cnt_q - 1'b1;
				if (aux_cnt_q == 2'd1) begin
					aux_busy_q <= 1'b0;
					aux_done_q <= 1'b1;
				end
			end
			if (cfg_valid) frame_pixels_q <= cfg_data;
			if (cmd.clr || cmd.walk) cnt_q <= (cnt_q == BIN_LAST) ? '0 : cnt_q + 1'b1;
			if (cmd.ld_wr) begin
				if (pix_q < rmin_q) rmin_q <= pix_q;
				if (pix_q > rmax_q) rmax_q <= pix_q;
				rsum_q <= rsum_q + 32'(pix_q);
				if (prior_q && load_idx_q < done_cnt_q) csum_q <= csum_q + 32'(absdiff);
				load_idx_q <= n_next;
			end
			if (cmd.restart) begin
				wl_q <= tlo_q;
				wh_q <= thi_q;
			end
			if (aux_done_q && op_q == OP_ELO)
				wl_q <= dneg_q ? wl_q - QW'(aux_quo_q) : wl_q + QW'(aux_quo_q);
			if (aux_done_q && op_q == OP_EHI)
				wh_q <= dneg_q ? wh_q - QW'(aux_quo_q) : wh_q + QW'(aux_quo_q);
			if (cmd.emit_stat) begin
				bank_q      <= ~bank_q;
				done_cnt_q  <= load_idx_q;
				prior_q     <= 1'b1;
				drain_idx_q <= '0;
				pending_q   <= 1'b1;
				load_idx_q  <= '0;
				rmin_q      <= 16'hffff;
				rmax_q      <= '0;
				rsum_q      <= '0;
				csum_q      <= '0;
			end
			if (cmd.emit_pix) begin
				if (pix_last) begin
					pending_q   <= 1'b0;
					drain_idx_q <= '0;
				end else begin
					drain_idx_q <= drain_idx_q + 1'b1;
				end
			end
			if (cmd.emit_pix || cmd.emit_stat) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			req_q <= req_type;
			pix_q <= raw_pixel;
		end
		walk_idx_s1 <= cnt_q;
		if (cmd.div_start) begin
			op_q   <= cmd.div_op;
			dneg_q <= ema_d < 0;
		end
		if (aux_start) begin
			aux_x_q   <= 36'(ema_mag) + 36'(2);
			aux_rem_q <= '0;
			aux_quo_q <= '0;
		end else if (aux_busy_q) begin
			if (op_q == OP_P100) begin
				aux_quo_q <= 36'(p100_prod[33:23]);
			end else begin
				aux_quo_q <= {aux_quo_q[17:0], aux_qc};
				aux_rem_q <= aux_r21[2:0];
				aux_x_q   <= {aux_x_q[17:0], 18'b0};
			end
		end
		if (cmd.div_start && cmd.div_op == OP_MEAN)
			chg100_q <= DIVW'({csum_q, 6'b0}) + DIVW'({csum_q, 5'b0}) + DIVW'({csum_q, 2'b0});
		if (aux_done_q && op_q == OP_P100) begin
			lo_t_q     <= lo_t;
			hi_t_q     <= hi_t;
			cum_q      <= '0;
			lo_found_q <= 1'b0;
			hi_found_q <= 1'b0;
			lo_bin_q   <= '0;
			hi_bin_q   <= BIN_LAST;
		end else if (walk_vld_s1) begin
			cum_q <= cum_next;
			if (!lo_found_q && cum_next >= lo_t_q) begin
				lo_found_q <= 1'b1;
				lo_bin_q   <= walk_idx_s1;
			end
			if (!hi_found_q && cum_next >= hi_t_q) begin
				hi_found_q <= 1'b1;
				hi_bin_q   <= walk_idx_s1;
			end
		end
		if (cmd.tgt) begin
			tlo_q <= tlo;
			thi_q <= thi;
		end
		if (cmd.dr_calc) begin
			num_q <= DIVW'((46'(num45) <<< 1) + 46'(denc));
			den_q <= DIVW'(denc) << 1;
			neg_q <= num45 < 0;
		end
		if (cmd.dr_sel) pixo_q <= neg_q ? 8'd0 : 8'd255;
		if (div_done && op_q == OP_PIX) pixo_q <= div_quo[7:0];
		if (div_done && op_q == OP_MEAN) mean_q <= div_quo[15:0];
		if (div_done && op_q == OP_CHG) chg_q <= div_quo[CHGW-1:0];
		if (cmd.emit_stat) begin
			kind_q  <= 1'b0;
			opix_q  <= '0;
			last_q  <= 1'b0;
			omin_q  <= rmin_q;
			omax_q  <= rmax_q;
			omean_q <= mean_q;
			ochg_q  <= have_prev ? chg_q : '0;
			owl_q   <= to_int(wl_q);
			owh_q   <= to_int(wh_q);
		end
		if (cmd.emit_pix) begin
			kind_q  <= 1'b1;
			opix_q  <= pixo_q;
			last_q  <= pix_last;
			omin_q  <= '0;
			omax_q  <= '0;
			omean_q <= '0;
			ochg_q  <= '0;
			owl_q   <= '0;
			owh_q   <= '0;
		end
	end

	always_comb begin
		sts.req_in   = req_type;
		sts.pending  = pending_q;
		sts.complete = n_next >= eff;
		sts.div_done = div_done || aux_done_q;
		sts.cnt_last = cnt_q == BIN_LAST;
		sts.direct   = neg_q || sat;
		sts.restart  = (wl_q < 0) || (wh_q < 0);
		sts.out_free = !out_valid_q || !out_stall;
	end

	assign out_valid       = out_valid_q;
	assign result_kind     = kind_q;
	assign pixel_out       = opix_q;
	assign is_last         = last_q;
	assign frame_min       = omin_q;
	assign frame_max       = omax_q;
	assign frame_mean      = omean_q;
	assign change_x100     = ochg_q;
	assign window_low_int  = $signed(owl_q);
	assign window_high_int = owh_q;

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_pix || cmd.emit_stat) |-> (!out_valid_q || !out_stall))
		else $error("word emitted over a stalled output word");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		load_idx_q <= MAXP)
		else $error("load index beyond frame bank");
	a_pending_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> done_cnt_q != '0)
		else $error("drain pending with empty frame");

endmodule

// File: hw/rtl/tpagc_ctrl.sv
// tpagc_ctrl: sequencer for loads, drains and the end-of-frame pass.
// Drives tpagc_dp commands from its status; depends on tpagc_pkg.
module tpagc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  tpagc_pkg::sts_t sts,
	output tpagc_pkg::cmd_t cmd
);
	import tpagc_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLR;
		else state_q <= state_d;
	end

	assign in_stall = state_q != S_IDLE;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLR: begin
				cmd.clr = 1'b1;
				if (sts.cnt_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					if (!sts.req_in) state_d = S_LD1;
					else if (sts.pending) state_d = S_DR1;
				end
			end
			S_LD1: state_d = S_LD2;
			S_LD2: begin
				cmd.ld_wr = 1'b1;
				state_d = sts.complete ? S_P100 : S_IDLE;
			end
			S_DR1: state_d = S_DR2;
			S_DR2: begin
				cmd.dr_calc = 1'b1;
				state_d = S_DR3;
			end
			S_DR3: begin
				cmd.dr_sel = 1'b1;
				if (sts.direct) begin
					state_d = S_DREMIT;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_op    = OP_PIX;
					state_d = S_DRDIV;
				end
			end
			S_DRDIV: if (sts.div_done) state_d = S_DREMIT;
			S_DREMIT: begin
				if (sts.out_free) begin
					cmd.emit_pix = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_P100: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = OP_P100;
				state_d = S_P100W;
			end
			S_P100W: if (sts.div_done) state_d = S_WALK;
			S_WALK: begin
				cmd.walk = 1'b1;
				if (sts.cnt_last) state_d = S_WALKE;
			end
			S_WALKE: state_d = S_TGT;
			S_TGT: begin
				cmd.tgt = 1'b1;
				state_d = S_EL;
			end
			S_EL: begin
				if (sts.restart) begin
					cmd.restart = 1'b1;
					state_d = S_MEAN;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_op    = OP_ELO;
					state_d = S_ELW;
				end
			end
			S_ELW: if (sts.div_done) state_d = S_EH;
			S_EH: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = OP_EHI;
				state_d = S_EHW;
			end
			S_EHW: if (sts.div_done) state_d = S_MEAN;
			S_MEAN: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = OP_MEAN;
				state_d = S_MEANW;
			end
			S_MEANW: if (sts.div_done) state_d = S_CHG;
			S_CHG: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = OP_CHG;
				state_d = S_CHGW;
			end
			S_CHGW: if (sts.div_done) state_d = S_SEMIT;
			S_SEMIT: begin
				if (sts.out_free) begin
					cmd.emit_stat = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// File: hw/rtl/thermal_percentile_agc_unit.sv
// thermal_percentile_agc_unit: top level. A load word passes states LD1 and LD2;
// a drain word passes DR1 to DR3, then DRDIV if scaled by the shared divider,
// then DREMIT. A frame-closing load then runs the end-of-frame pass: the histogram
// walk reads one bin per cycle, then short constant divisions and two serial
// divisions finish. After reset the histogram is cleared, one bin per cycle,
// during which no input word is taken; configuration writes are always taken.
module thermal_percentile_agc_unit #(
	parameter int MAX_PIXELS = tpagc_pkg::MAX_PIXELS_DEF,
	parameter int BIN_COUNT  = tpagc_pkg::BIN_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic [15:0]        raw_pixel,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               result_kind,
	output logic [7:0]         pixel_out,
	output logic               is_last,
	output logic [15:0]        frame_min,
	output logic [15:0]        frame_max,
	output logic [15:0]        frame_mean,
	output logic [22:0]        change_x100,
	output logic signed [16:0] window_low_int,
	output logic [16:0]        window_high_int,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [16:0]        cfg_data
);
	import tpagc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tpagc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tpagc_dp #(
		.MAX_PIXELS (MAX_PIXELS),
		.BIN_COUNT  (BIN_COUNT)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.req_type        (req_type),
		.raw_pixel       (raw_pixel),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.result_kind     (result_kind),
		.pixel_out       (pixel_out),
		.is_last         (is_last),
		.frame_min       (frame_min),
		.frame_max       (frame_max),
		.frame_mean      (frame_mean),
		.change_x100     (change_x100),
		.window_low_int  (window_low_int),
		.window_high_int (window_high_int)
	);

endmodule
